### sv/bare_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bare_pkg;
	localparam int SampleW = 32;
	localparam int CfgW = 16;
	localparam int SumW = 48;
	localparam int SqW = 64;
	localparam int DivW = 64;
	localparam logic [0:0] RegSpb = 1'b0;
	localparam logic [0:0] RegBlk = 1'b1;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_DIV_MEAN,
		ST_SQ_MEAN,
		ST_DIV_RMEAN,
		ST_SQ_RMEAN,
		ST_DIV_MSQ,
		ST_DIV_VAR,
		ST_SQRT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### sv/block_average_running_error.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Contents
// s_axis    in         tdata[31:0] sample
// m_axis    out        tdata[15:0] block_index, [47:16] running_mean,
//                      [79:48] running_error; tlast last_block
// cfg       in         wr_en, wr_index, wr_data
// A sample that does not end a block is added to the block sum.
// A sample that ends a block starts a sequence of serial divides, squares and
// a square root; the result is valid once that sequence ends, and the first
// block, which needs no error term, skips the last two divides and the root.
// Reset clears all counters and sums; the result register holds while
// m_axis_tready is low, and input is held off until the result is taken.
module block_average_running_error (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [31:0]           s_axis_tdata,   // sample
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [79:0]                m_axis_tdata,   // block_index, running_mean, running_error
	output logic                       m_axis_tlast,   // last_block
	input  wire logic                  wr_en,
	input  wire logic [0:0]            wr_index,
	input  wire logic [bare_pkg::CfgW-1:0] wr_data
);
	import bare_pkg::*;

	state_t state_q, state_d;
	logic [CfgW-1:0] spb_q, blk_q, sib_q, done_q;
	logic signed [SumW-1:0] bsum_q, som_q;
	logic [SqW-1:0] sosq_q;
	logic fin_q;

	// Shared serial unit: restoring divider, shift-add multiplier, square root.
	logic [DivW-1:0] a_q, b_q, r_q, acc_q;
	logic [6:0] cnt_q;
	logic neg_q;
	logic [31:0] mag_q;
	logic signed [SumW-1:0] mean_q;
	logic [31:0] rmean_q, err_q;
	logic [SqW-1:0] m2_q;
	logic [CfgW-1:0] idx_q;
	logic ovalid_q, olast_q;

	logic [CfgW-1:0] spb_eff;
	logic signed [SumW-1:0] nsum;
	logic signed [SumW-1:0] som_nx;
	logic accept;
	logic [DivW:0] rem_sh;
	logic q_bit;
	logic [DivW-1:0] q_full;
	logic [SqW:0] mul_sum;
	logic [SqW-1:0] mul_next;
	logic [DivW+1:0] sq_rem, sq_try;

	assign spb_eff = (spb_q == '0) ? CfgW'(1) : spb_q;
	assign s_axis_tready = (state_q == ST_ACC) && !ovalid_q;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign nsum = bsum_q + SumW'(signed'(s_axis_tdata));
	assign som_nx = som_q + mean_q;
	assign rem_sh = {r_q, a_q[DivW-1]};
	assign q_bit = rem_sh >= {1'b0, b_q};
	assign q_full = {a_q[DivW-2:0], q_bit};
	assign mul_sum = {1'b0, acc_q} + {1'b0, a_q[31:0], 32'd0};
	assign mul_next = mag_q[0] ? mul_sum[SqW:1] : {1'b0, acc_q[SqW-1:1]};
	assign sq_rem = {r_q, a_q[DivW-1:DivW-2]};
	assign sq_try = {acc_q, 2'b01};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC: if (accept && !fin_q && done_q < blk_q && sib_q + 1'b1 >= spb_eff)
				state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: if (cnt_q == 7'd0) state_d = ST_SQ_MEAN;
			ST_SQ_MEAN: if (cnt_q == 7'd0) state_d = ST_DIV_RMEAN;
			ST_DIV_RMEAN: if (cnt_q == 7'd0) state_d = ST_SQ_RMEAN;
			ST_SQ_RMEAN: if (cnt_q == 7'd0) state_d = (idx_q == '0) ? ST_OUT : ST_DIV_MSQ;
			ST_DIV_MSQ: if (cnt_q == 7'd0) state_d = ST_DIV_VAR;
			ST_DIV_VAR: if (cnt_q == 7'd0) state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == 7'd0) state_d = ST_OUT;
			ST_OUT: state_d = ST_ACC;
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			spb_q <= CfgW'(100);
			blk_q <= CfgW'(100);
			sib_q <= '0;
			bsum_q <= '0;
			done_q <= '0;
			som_q <= '0;
			sosq_q <= '0;
			fin_q <= 1'b0;
			ovalid_q <= 1'b0;
			cnt_q <= '0;
			a_q <= '0;
			b_q <= '0;
			r_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			mag_q <= '0;
			mean_q <= '0;
			rmean_q <= '0;
			err_q <= '0;
			m2_q <= '0;
			idx_q <= '0;
			olast_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				if (wr_index == RegSpb) spb_q <= wr_data;
				else spb_q <= spb_q;
				if (wr_index == RegBlk) blk_q <= wr_data;
			end
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
			case (state_q)
				ST_ACC: if (accept && !fin_q && done_q < blk_q) begin
					if (sib_q + 1'b1 >= spb_eff) begin
						sib_q <= '0;
						bsum_q <= '0;
						idx_q <= done_q;
						neg_q <= nsum[SumW-1];
						a_q <= DivW'(nsum[SumW-1] ? -nsum : nsum) << (DivW - SumW);
						b_q <= DivW'(spb_eff);
						r_q <= '0;
						cnt_q <= 7'(SumW - 1);
					end else begin
						sib_q <= sib_q + 1'b1;
						bsum_q <= nsum;
					end
				end
				ST_DIV_MEAN, ST_DIV_RMEAN, ST_DIV_MSQ, ST_DIV_VAR: begin
					if (q_bit) begin
						r_q <= DivW'(rem_sh - {1'b0, b_q});
						a_q <= {a_q[DivW-2:0], 1'b1};
					end else begin
						r_q <= rem_sh[DivW-1:0];
						a_q <= {a_q[DivW-2:0], 1'b0};
					end
					if (cnt_q == 7'd0) begin
						if (state_q == ST_DIV_MEAN) begin
							mean_q <= neg_q ? -signed'(q_full[SumW-1:0])
								: signed'(q_full[SumW-1:0]);
							mag_q <= q_full[31:0];
							a_q <= q_full;
							acc_q <= '0;
							cnt_q <= 7'd31;
						end else if (state_q == ST_DIV_RMEAN) begin
							rmean_q <= neg_q ? -q_full[31:0] : q_full[31:0];
							mag_q <= q_full[31:0];
							a_q <= q_full;
							acc_q <= '0;
							cnt_q <= 7'd31;
						end else if (state_q == ST_DIV_MSQ) begin
							if (q_full > m2_q)
								a_q <= q_full - m2_q;
							else
								a_q <= '0;
							b_q <= DivW'(idx_q);
							r_q <= '0;
							cnt_q <= 7'(DivW - 1);
						end else begin
							a_q <= {q_full[DivW-17:0], 16'd0};
							r_q <= '0;
							acc_q <= '0;
							cnt_q <= 7'd31;
						end
					end
				end
				ST_SQ_MEAN, ST_SQ_RMEAN: begin
					acc_q <= mul_next;
					mag_q <= mag_q >> 1;
					if (cnt_q == 7'd0) begin
						if (state_q == ST_SQ_MEAN) begin
							sosq_q <= sosq_q + (mul_next >> 16);
							som_q <= som_nx;
							neg_q <= som_nx < 0;
							a_q <= DivW'(som_nx < 0 ? -som_nx : som_nx) << (DivW - SumW);
							b_q <= DivW'(idx_q) + 1'b1;
							r_q <= '0;
							cnt_q <= 7'(SumW - 1);
						end else begin
							m2_q <= mul_next >> 16;
							a_q <= sosq_q;
							b_q <= DivW'(idx_q) + 1'b1;
							r_q <= '0;
							cnt_q <= 7'(DivW - 1);
							err_q <= '0;
						end
					end
				end
				ST_SQRT: begin
					a_q <= a_q << 2;
					if (sq_rem >= sq_try) begin
						r_q <= DivW'(sq_rem - sq_try);
						acc_q <= {acc_q[DivW-2:0], 1'b1};
					end else begin
						r_q <= DivW'(sq_rem);
						acc_q <= {acc_q[DivW-2:0], 1'b0};
					end
					if (cnt_q == 7'd0)
						err_q <= {acc_q[30:0], sq_rem >= sq_try};
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					olast_q <= (done_q + 1'b1) == blk_q;
					done_q <= done_q + 1'b1;
					if (done_q + 1'b1 >= blk_q) fin_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {err_q, rmean_q, idx_q};
	assign m_axis_tlast = olast_q;
endmodule
`default_nettype wire
